/* sv/hjui_pkg.sv */
// shared types, constants and state codes for the joystick report to ui events block
package hjui_pkg;

  localparam int NUM_STICKS_DEF = 4;

  // divider widths: |(2*v - hi - lo) * 127| stays below 2^41, |hi - lo| at most 2^32
  localparam int DVD_W = 42;
  localparam int DSR_W = 33;
  localparam int NB_W  = $clog2(DVD_W + 1);

  localparam logic [31:0] USAGE_X      = 32'h0001_0030;
  localparam logic [31:0] USAGE_Y      = 32'h0001_0031;
  localparam logic [31:0] PAGE_MASK    = 32'hffff_0000;
  localparam logic [31:0] BUTTON_PAGE  = 32'h0009_0000;
  localparam logic [7:0]  AXIS_LIMIT   = 8'd127;
  localparam logic [6:0]  DEF_THRESHOLD = 7'd63;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_FIRE_ONE  = 3'd1;
  localparam logic [2:0] CFG_FIRE_TWO  = 3'd2;
  localparam logic [2:0] CFG_PREV_KEY  = 3'd3;
  localparam logic [2:0] CFG_NEXT_KEY  = 3'd4;
  localparam logic [2:0] CFG_EXCLUSIVE = 3'd5;
  localparam logic [2:0] CFG_PRESENT   = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_AXIS   = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  localparam logic [2:0] TRG_NONE = 3'd0;

  // emit sequence: steps 0..3 buttons, 4..7 directions (step number is the trigger id)
  localparam logic [3:0] STEP_FIRST_DIR = 4'd4;
  localparam logic [3:0] STEP_AXIS      = 4'd8;
  localparam logic [3:0] STEP_REPORT    = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_WALK,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [NB_W-1:0] nbits;
  } div_ctl_t;

endpackage

/* sv/hjui_div.sv */
// bit-serial restoring divider on magnitudes, one quotient bit per cycle
module hjui_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hjui_pkg::div_ctl_t          ctl,
  input  logic [hjui_pkg::DVD_W-1:0]  dividend,
  input  logic [hjui_pkg::DSR_W-1:0]  divisor,
  output logic                        done,
  output logic [hjui_pkg::DVD_W-1:0]  quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [hjui_pkg::NB_W-1:0]    cnt_r;
  logic [hjui_pkg::DVD_W-1:0]   dvd_r;
  logic [hjui_pkg::DVD_W-1:0]   quo_r;
  logic [hjui_pkg::DSR_W-1:0]   rem_r;
  logic [hjui_pkg::DSR_W-1:0]   dsr_r;
  logic [hjui_pkg::DSR_W+1:0]   trial;

  // dividend is left aligned, so only the top nbits are walked
  assign trial = {1'b0, rem_r, dvd_r[hjui_pkg::DVD_W-1]} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hjui_pkg::NB_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[hjui_pkg::DVD_W-2:0], 1'b0};
      if (!trial[hjui_pkg::DSR_W+1]) begin
        rem_r <= trial[hjui_pkg::DSR_W-1:0];
        quo_r <= {quo_r[hjui_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[hjui_pkg::DSR_W-2:0], dvd_r[hjui_pkg::DVD_W-1]};
        quo_r <= {quo_r[hjui_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/hid_joystick_report_to_ui_events_core.sv */
// joystick report to ui events: top level with sequencer, slot store and ui state
//
//  channel | signals                                  | handshake
//  cfg     | cfg_we, cfg_index, cfg_wdata             | write on cfg_we, no wait
//  in      | in_stick_index .. in_logical_max         | in_valid / in_ready
//  out     | out_event_kind .. out_last_event         | out_valid / out_ready
//
// the serial divider sets most of the time from one accept to the next, and output stalls add to it.
// no averaging divides run for an exclusive slot, and none run when no slot is counted.
// in_ready is high only in idle; results leave through one output register, and the
// emit steps wait while out_valid is high and out_ready low.
// reset is synchronous, clears slot store, ui state and out_valid, sets config to its defaults.
module hid_joystick_report_to_ui_events_core #(
  parameter int NUM_STICKS = hjui_pkg::NUM_STICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_stick_index,
  input  logic [31:0]       in_usage_code,
  input  logic signed [31:0] in_report_value,
  input  logic signed [31:0] in_logical_min,
  input  logic signed [31:0] in_logical_max,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [2:0]        out_trigger_id,
  output logic signed [7:0] out_axis_x_out,
  output logic signed [7:0] out_axis_y_out,
  output logic [7:0]        out_buttons_out,
  output logic              out_last_event
);

  localparam int IDX_W = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;
  localparam int CNT_W = $clog2(NUM_STICKS + 1);
  localparam int SUM_W = 8 + CNT_W;
  localparam int DVD_W = hjui_pkg::DVD_W;
  localparam int DSR_W = hjui_pkg::DSR_W;

  // configuration
  logic [6:0] thr_cfg_r;
  logic [2:0] fire1_r, fire2_r, prev_r, next_r;
  logic [3:0] excl_mask_r, pres_mask_r;

  // slot store
  logic signed [7:0] stk_x_r [NUM_STICKS];
  logic signed [7:0] stk_y_r [NUM_STICKS];
  logic [7:0]        stk_b_r [NUM_STICKS];

  // ui state
  logic [3:0]        ui_flags_r;
  logic signed [7:0] ui_x_r, ui_y_r;

  // per item
  hjui_pkg::state_t  state_r, state_nxt;
  logic [1:0]        s_r;
  logic              is_x_r, is_y_r, is_btn_r, btn_set_r, excl_r;
  logic [2:0]        btn_bit_r;
  logic signed [34:0] num_r;
  logic signed [32:0] den_r;
  logic              neg_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  logic [3:0]        nf_r;
  logic signed [7:0] nx_r, ny_r;
  logic signed [7:0] cur_x_r, cur_y_r;
  logic [7:0]        cur_b_r;
  logic [3:0]        step_r;

  // output register
  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [2:0]        trg_r;
  logic signed [7:0] ox_r, oy_r;
  logic [7:0]        ob_r;
  logic              olast_r;

  // divider
  hjui_pkg::div_ctl_t div_ctl;
  logic [DVD_W-1:0]   div_dvd;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;
  logic               div_neg;

  logic               acc;
  logic               idx_ok;
  logic signed [41:0] prod;
  logic               den_zero;
  logic [7:0]         sat_mag;
  logic signed [7:0]  sat_res;
  logic [SUM_W-1:0]   sum_mag;
  logic signed [SUM_W-1:0] sum_sel;

  // walk
  logic [IDX_W-1:0]   widx;
  logic               at_slot;
  logic [7:0]         wb_raw, wb;
  logic               counted;
  logic               walk_last;

  // emit
  logic signed [8:0]  thr9;
  logic [3:0]         dir_new, dir_old;
  logic               cand_now, cand_was, hit, emit_load;
  logic [1:0]         e_kind;
  logic [2:0]         e_trg;
  logic signed [7:0]  e_x, e_y;
  logic [7:0]         e_b;

  assign acc    = in_valid && in_ready;
  assign idx_ok = int'(in_stick_index) < NUM_STICKS;

  assign prod     = ({{7{num_r[34]}}, num_r} <<< 7) - {{7{num_r[34]}}, num_r};
  assign den_zero = (den_r == '0);

  // saturate the quotient magnitude and apply the sign
  assign sat_mag = (div_quo > DVD_W'(hjui_pkg::AXIS_LIMIT)) ? hjui_pkg::AXIS_LIMIT
                                                            : div_quo[7:0];
  assign sat_res = neg_r ? -$signed(sat_mag) : $signed(sat_mag);

  assign sum_sel = (state_r == hjui_pkg::ST_DIVY_GO) ? sy_r : sx_r;
  assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  // walk over the slots, with the button update folded into the visit of slot s
  assign widx      = i_r[IDX_W-1:0];
  assign at_slot   = (int'(i_r) == int'(s_r));
  assign wb_raw    = stk_b_r[widx];
  always_comb begin
    wb = wb_raw;
    if (at_slot && is_btn_r) wb[btn_bit_r] = btn_set_r;
  end
  assign counted   = (int'(i_r) < 4) && pres_mask_r[2'(i_r)] && !excl_mask_r[2'(i_r)];
  assign walk_last = (int'(i_r) == NUM_STICKS - 1);

  // divider control and operands
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.nbits = hjui_pkg::NB_W'(SUM_W);
    div_dvd       = {sum_mag, {(DVD_W - SUM_W){1'b0}}};
    div_dsr       = DSR_W'(cnt_r);
    div_neg       = sum_sel[SUM_W-1];
    unique case (state_r)
      hjui_pkg::ST_MUL: begin
        div_ctl.start = !den_zero;
        div_ctl.nbits = hjui_pkg::NB_W'(DVD_W);
        div_dvd       = prod[41] ? DVD_W'(-prod) : DVD_W'(prod);
        div_dsr       = den_r[32] ? DSR_W'(-den_r) : DSR_W'(den_r);
        div_neg       = prod[41] ^ den_r[32];
      end
      hjui_pkg::ST_DIVX_GO, hjui_pkg::ST_DIVY_GO: begin
        div_ctl.start = (cnt_r != '0);
      end
      default: ;
    endcase
  end

  hjui_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // candidate results
  assign thr9 = (cnt_r != '0) ? $signed({2'b00, thr_cfg_r})
                              : $signed({2'b00, hjui_pkg::DEF_THRESHOLD});
  assign dir_new = {ny_r <= -thr9, ny_r >= thr9, nx_r <= -thr9, nx_r >= thr9};
  assign dir_old = {ui_y_r <= -thr9, ui_y_r >= thr9, ui_x_r <= -thr9, ui_x_r >= thr9};

  always_comb begin
    cand_now = 1'b0;
    cand_was = 1'b0;
    hit      = 1'b0;
    e_kind   = hjui_pkg::KIND_REPORT;
    e_trg    = hjui_pkg::TRG_NONE;
    e_x      = '0;
    e_y      = '0;
    e_b      = '0;
    priority if (step_r < hjui_pkg::STEP_FIRST_DIR) begin
      cand_now = nf_r[step_r[1:0]];
      cand_was = ui_flags_r[step_r[1:0]];
      hit      = !excl_r && (cand_now != cand_was);
      e_kind   = cand_now ? hjui_pkg::KIND_DOWN : hjui_pkg::KIND_UP;
      e_trg    = step_r[2:0];
    end else if (step_r < hjui_pkg::STEP_AXIS) begin
      cand_now = dir_new[step_r[1:0]];
      cand_was = dir_old[step_r[1:0]];
      hit      = !excl_r && (cand_now != cand_was);
      e_kind   = cand_now ? hjui_pkg::KIND_DOWN : hjui_pkg::KIND_UP;
      e_trg    = step_r[2:0];
    end else if (step_r == hjui_pkg::STEP_AXIS) begin
      hit    = !excl_r && ((nx_r != ui_x_r) || (ny_r != ui_y_r));
      e_kind = hjui_pkg::KIND_AXIS;
      e_x    = nx_r;
      e_y    = ny_r;
    end else begin
      hit    = 1'b1;
      e_kind = hjui_pkg::KIND_REPORT;
      e_x    = cur_x_r;
      e_y    = cur_y_r;
      e_b    = cur_b_r;
    end
  end

  assign emit_load = (state_r == hjui_pkg::ST_EMIT) && hit && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hjui_pkg::ST_IDLE:
        if (acc && idx_ok) begin
          if ((in_usage_code == hjui_pkg::USAGE_X) || (in_usage_code == hjui_pkg::USAGE_Y))
            state_nxt = hjui_pkg::ST_MUL;
          else
            state_nxt = hjui_pkg::ST_WALK;
        end
      hjui_pkg::ST_MUL:
        state_nxt = den_zero ? hjui_pkg::ST_WALK : hjui_pkg::ST_SCALE;
      hjui_pkg::ST_SCALE:
        if (div_done) state_nxt = hjui_pkg::ST_WALK;
      hjui_pkg::ST_WALK:
        if (walk_last) state_nxt = excl_r ? hjui_pkg::ST_EMIT : hjui_pkg::ST_DIVX_GO;
      hjui_pkg::ST_DIVX_GO:
        state_nxt = (cnt_r != '0) ? hjui_pkg::ST_DIVX_WAIT : hjui_pkg::ST_EMIT;
      hjui_pkg::ST_DIVX_WAIT:
        if (div_done) state_nxt = hjui_pkg::ST_DIVY_GO;
      hjui_pkg::ST_DIVY_GO:
        state_nxt = hjui_pkg::ST_DIVY_WAIT;
      hjui_pkg::ST_DIVY_WAIT:
        if (div_done) state_nxt = hjui_pkg::ST_EMIT;
      hjui_pkg::ST_EMIT:
        if (emit_load && (step_r == hjui_pkg::STEP_REPORT)) state_nxt = hjui_pkg::ST_IDLE;
      default: state_nxt = hjui_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state_r == hjui_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hjui_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_cfg_r   <= hjui_pkg::DEF_THRESHOLD;
      fire1_r     <= 3'd0;
      fire2_r     <= 3'd1;
      prev_r      <= 3'd4;
      next_r      <= 3'd5;
      excl_mask_r <= '0;
      pres_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hjui_pkg::CFG_THRESHOLD: thr_cfg_r   <= cfg_wdata;
        hjui_pkg::CFG_FIRE_ONE:  fire1_r     <= cfg_wdata[2:0];
        hjui_pkg::CFG_FIRE_TWO:  fire2_r     <= cfg_wdata[2:0];
        hjui_pkg::CFG_PREV_KEY:  prev_r      <= cfg_wdata[2:0];
        hjui_pkg::CFG_NEXT_KEY:  next_r      <= cfg_wdata[2:0];
        hjui_pkg::CFG_EXCLUSIVE: excl_mask_r <= cfg_wdata[3:0];
        hjui_pkg::CFG_PRESENT:   pres_mask_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        stk_x_r[k] <= '0;
        stk_y_r[k] <= '0;
        stk_b_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_STICKS; k++) begin
        if (k == int'(s_r)) begin
          if ((state_r == hjui_pkg::ST_MUL && den_zero) ||
              (state_r == hjui_pkg::ST_SCALE && div_done)) begin
            if (is_x_r) stk_x_r[k] <= (state_r == hjui_pkg::ST_MUL) ? 8'sd0 : sat_res;
            if (is_y_r) stk_y_r[k] <= (state_r == hjui_pkg::ST_MUL) ? 8'sd0 : sat_res;
          end
          if (state_r == hjui_pkg::ST_WALK && at_slot && is_btn_r) stk_b_r[k] <= wb;
        end
      end
    end
  end

  // item capture, walk, averaging
  always_ff @(posedge clk) begin
    if (acc) begin
      s_r       <= in_stick_index;
      is_x_r    <= (in_usage_code == hjui_pkg::USAGE_X);
      is_y_r    <= (in_usage_code == hjui_pkg::USAGE_Y);
      is_btn_r  <= ((in_usage_code & hjui_pkg::PAGE_MASK) == hjui_pkg::BUTTON_PAGE) &&
                   (in_usage_code[15:0] >= 16'd1) && (in_usage_code[15:0] <= 16'd8);
      btn_bit_r <= 3'(in_usage_code[3:0] - 4'd1);
      btn_set_r <= (in_report_value != '0);
      excl_r    <= excl_mask_r[in_stick_index];
      num_r     <= {{2{in_report_value[31]}}, in_report_value, 1'b0}
                   - {{3{in_logical_max[31]}}, in_logical_max}
                   - {{3{in_logical_min[31]}}, in_logical_min};
      den_r     <= {in_logical_max[31], in_logical_max} - {in_logical_min[31], in_logical_min};
      i_r       <= '0;
      cnt_r     <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      nf_r      <= '0;
      nx_r      <= '0;
      ny_r      <= '0;
      step_r    <= '0;
    end
    if (state_r == hjui_pkg::ST_MUL) neg_r <= div_neg;
    if (state_r == hjui_pkg::ST_DIVX_GO || state_r == hjui_pkg::ST_DIVY_GO) neg_r <= div_neg;
    if (state_r == hjui_pkg::ST_WALK) begin
      i_r <= i_r + 1'b1;
      if (at_slot) begin
        cur_x_r <= stk_x_r[widx];
        cur_y_r <= stk_y_r[widx];
        cur_b_r <= wb;
      end
      if (counted) begin
        sx_r  <= sx_r + {{(SUM_W-8){stk_x_r[widx][7]}}, stk_x_r[widx]};
        sy_r  <= sy_r + {{(SUM_W-8){stk_y_r[widx][7]}}, stk_y_r[widx]};
        cnt_r <= cnt_r + 1'b1;
        nf_r  <= nf_r | {wb[next_r], wb[prev_r], wb[fire2_r], wb[fire1_r]};
      end
    end
    if (state_r == hjui_pkg::ST_DIVX_WAIT && div_done) nx_r <= sat_res;
    if (state_r == hjui_pkg::ST_DIVY_WAIT && div_done) ny_r <= sat_res;
    if (state_r == hjui_pkg::ST_EMIT && (emit_load || !hit)) step_r <= step_r + 1'b1;
  end

  // ui state, committed with the final result unless the slot is exclusive
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ui_flags_r <= '0;
      ui_x_r     <= '0;
      ui_y_r     <= '0;
    end else if (emit_load && (step_r == hjui_pkg::STEP_REPORT) && !excl_r) begin
      ui_flags_r <= nf_r;
      ui_x_r     <= nx_r;
      ui_y_r     <= ny_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      kind_r  <= e_kind;
      trg_r   <= e_trg;
      ox_r    <= e_x;
      oy_r    <= e_y;
      ob_r    <= e_b;
      olast_r <= (step_r == hjui_pkg::STEP_REPORT);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_trigger_id  = trg_r;
  assign out_axis_x_out  = ox_r;
  assign out_axis_y_out  = oy_r;
  assign out_buttons_out = ob_r;
  assign out_last_event  = olast_r;

endmodule
